>>> hw/rtl/sgw_pkg.sv
// Shared types, codes and defaults for the scatter-gather segment walker.
package sgw_pkg;

    // Field widths of the two channels
    localparam int CMD_W      = 2;
    localparam int FIELD_AW   = 48;
    localparam int LEN_W      = 32;
    localparam int OFS_W      = 38;
    localparam int STAT_W     = 2;

    // Defaults for the top level parameters
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF   = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_WALK_IN  = 2'd2,
        CMD_WALK_OUT = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MORE = 2'd1,
        ST_FULL = 2'd2
    } resp_code_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_APPEND_ADD,
        S_CLAMP1,
        S_CLAMP2,
        S_FIND_REQ,
        S_FIND_ADD,
        S_FIND_CMP,
        S_FIND_WITHIN,
        S_EMIT_AVAIL,
        S_EMIT_TAKE,
        S_EMIT_ADDR,
        S_EMIT_REM,
        S_EMIT_COV,
        S_EMIT_PUSH,
        S_EMIT_NEXT,
        S_EMIT_REQ,
        S_FINISH
    } state_t;

endpackage

>>> hw/rtl/sgw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgw_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sgw_alu.sv
// Shared add/subtract unit with borrow flag, used for the append and walk arithmetic.
module sgw_alu #(
    parameter int W = 49
) (
    input  logic         sub,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] result,
    output logic         borrow
);

    logic [W:0] sum;

    // a + b, or a + ~b + 1 for a - b; no carry out on subtract means a < b
    assign sum    = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
    assign result = sum[W-1:0];
    assign borrow = sub & ~sum[W];

endmodule

>>> hw/rtl/scatter_gather_segment_walker.sv
// Top level: segment list, walk sequencer and output register.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | command, phys_addr, length, start_offset,
//          |                      | buffer_length
//  out     | out_valid / out_ready| status, seg_addr, seg_length, covered_total, last
//
// A walk passes over the entries that end at or before the start offset, then emits a
// segment per entry until the length is covered (none for a zero-size entry), its sums
// going through the one shared adder and its entries through the list RAM read; a walk
// with no start entry or nothing to cover emits no segment.
// Reset clears the list count, total, sequencer, held-segment flag and out_valid at once.
// in_ready is high only while the sequencer is idle; a full output register holds
// the sequencer at the next result until the downstream side takes it.
module scatter_gather_segment_walker
    import sgw_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [FIELD_AW-1:0] phys_addr,
    input  logic [LEN_W-1:0]    length,
    input  logic [OFS_W-1:0]    start_offset,
    input  logic [OFS_W-1:0]    buffer_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [FIELD_AW-1:0] seg_addr,
    output logic [LEN_W-1:0]    seg_length,
    output logic [OFS_W-1:0]    covered_total,
    output logic                last
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W  = ADDR_BITS + LEN_W;
    localparam int ALU_W  = ((ADDR_BITS > OFS_W) ? ADDR_BITS : OFS_W) + 1;

    // Sequencer
    state_t state_reg, state_next;

    // Latched transaction
    cmd_t               cmd_reg, cmd_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic [OFS_W-1:0]   buflen_reg, buflen_next;
    resp_code_t         resp_status_reg, resp_status_next;

    // List bookkeeping
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [OFS_W-1:0]   total_reg, total_next;

    // Walk working registers
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [OFS_W-1:0]     remaining_reg, remaining_next;
    logic [OFS_W-1:0]     start_reg, start_next;
    logic [OFS_W-1:0]     end_reg, end_next;
    logic [LEN_W-1:0]     within_reg, within_next;
    logic [LEN_W-1:0]     avail_reg, avail_next;
    logic [LEN_W-1:0]     take_reg, take_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [OFS_W-1:0]     covered_reg, covered_next;

    // Segment held back until it is known whether it is the final one
    logic                 pend_valid_reg, pend_valid_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [LEN_W-1:0]     pend_len_reg, pend_len_next;
    logic [OFS_W-1:0]     pend_cov_reg, pend_cov_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    resp_code_t           out_status_reg, out_status_next;
    logic [FIELD_AW-1:0]  out_addr_reg, out_addr_next;
    logic [LEN_W-1:0]     out_len_reg, out_len_next;
    logic [OFS_W-1:0]     out_cov_reg, out_cov_next;
    logic                 out_last_reg, out_last_next;

    // Shared adder and list RAM
    logic             alu_sub;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_borrow;
    logic             ram_we;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    logic [LEN_W-1:0]     ent_bytes;
    logic [ADDR_BITS-1:0] ent_phys;

    logic in_fire, out_free, list_full, walk_done;

    assign in_fire   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign list_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign walk_done = (remaining_reg == '0) || (idx_reg == count_reg);
    assign ent_phys  = ram_rdata[ADDR_BITS-1:0];
    assign ent_bytes = ram_rdata[ADDR_BITS +: LEN_W];

    sgw_alu #(
        .W (ALU_W)
    ) u_alu (
        .sub    (alu_sub),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    sgw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_CLEAR:  state_next = S_FINISH;
                        CMD_APPEND: state_next = list_full ? S_FINISH : S_APPEND_ADD;
                        default:    state_next = S_CLAMP1;
                    endcase
                end
            end
            S_APPEND_ADD:  state_next = S_FINISH;
            S_CLAMP1:      state_next = S_CLAMP2;
            S_CLAMP2:      state_next = S_FIND_REQ;
            S_FIND_REQ:    state_next = walk_done ? S_FINISH : S_FIND_ADD;
            S_FIND_ADD:    state_next = S_FIND_CMP;
            S_FIND_CMP:    state_next = alu_borrow ? S_FIND_WITHIN : S_FIND_REQ;
            S_FIND_WITHIN: state_next = S_EMIT_AVAIL;
            S_EMIT_AVAIL:  state_next = S_EMIT_TAKE;
            S_EMIT_TAKE:   state_next = (avail_reg == '0) ? S_EMIT_NEXT : S_EMIT_ADDR;
            S_EMIT_ADDR:   state_next = S_EMIT_REM;
            S_EMIT_REM:    state_next = S_EMIT_COV;
            S_EMIT_COV:    state_next = S_EMIT_PUSH;
            S_EMIT_PUSH:
            begin
                if (~pend_valid_reg || out_free)
                begin
                    state_next = S_EMIT_NEXT;
                end
            end
            S_EMIT_NEXT:   state_next = S_EMIT_REQ;
            S_EMIT_REQ:    state_next = walk_done ? S_FINISH : S_EMIT_AVAIL;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, adder operands, list write
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        alu_sub   = 1'b0;
        alu_a     = '0;
        alu_b     = '0;
        ram_we    = 1'b0;
        ram_wdata = {length, ADDR_BITS'(phys_addr)};
        case (state_reg)
            S_IDLE:
            begin
                ram_we = in_valid && (cmd_t'(command) == CMD_APPEND) && ~list_full;
            end
            S_APPEND_ADD:
            begin
                alu_a = ALU_W'(total_reg);
                alu_b = ALU_W'(len_reg);
            end
            S_CLAMP1:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(len_reg);
                alu_b   = ALU_W'(total_reg);
            end
            S_CLAMP2:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(buflen_reg);
                alu_b   = ALU_W'(remaining_reg);
            end
            S_FIND_ADD:
            begin
                alu_a = ALU_W'(start_reg);
                alu_b = ALU_W'(ent_bytes);
            end
            S_FIND_CMP:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(offset_reg);
                alu_b   = ALU_W'(end_reg);
            end
            S_FIND_WITHIN:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(offset_reg);
                alu_b   = ALU_W'(start_reg);
            end
            S_EMIT_AVAIL:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(ent_bytes);
                alu_b   = ALU_W'(within_reg);
            end
            S_EMIT_TAKE:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(remaining_reg);
                alu_b   = ALU_W'(avail_reg);
            end
            S_EMIT_ADDR:
            begin
                alu_a = ALU_W'(ent_phys);
                alu_b = ALU_W'(within_reg);
            end
            S_EMIT_REM:
            begin
                alu_sub = 1'b1;
                alu_a   = ALU_W'(remaining_reg);
                alu_b   = ALU_W'(take_reg);
            end
            S_EMIT_COV:
            begin
                alu_a = ALU_W'(covered_reg);
                alu_b = ALU_W'(take_reg);
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cmd_next         = cmd_reg;
        len_next         = len_reg;
        offset_next      = offset_reg;
        buflen_next      = buflen_reg;
        resp_status_next = resp_status_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        idx_next         = idx_reg;
        remaining_next   = remaining_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        within_next      = within_reg;
        avail_next       = avail_reg;
        take_next        = take_reg;
        addr_next        = addr_reg;
        covered_next     = covered_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        pend_len_next    = pend_len_reg;
        pend_cov_next    = pend_cov_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_len_next     = out_len_reg;
        out_cov_next     = out_cov_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next         = cmd_t'(command);
                    len_next         = length;
                    offset_next      = start_offset;
                    buflen_next      = buffer_length;
                    idx_next         = '0;
                    start_next       = '0;
                    covered_next     = '0;
                    pend_valid_next  = 1'b0;
                    resp_status_next = ST_OK;
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (list_full)
                            begin
                                resp_status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            resp_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_APPEND_ADD:
            begin
                total_next = alu_res[OFS_W-1:0];
            end
            // count = min(length, total)
            S_CLAMP1:
            begin
                remaining_next = alu_borrow ? OFS_W'(len_reg) : total_reg;
            end
            // want = min(buffer length, count)
            S_CLAMP2:
            begin
                remaining_next = alu_borrow ? buflen_reg : remaining_reg;
            end
            S_FIND_ADD:
            begin
                end_next = alu_res[OFS_W-1:0];
            end
            // entry ends at or before the offset: move on
            S_FIND_CMP:
            begin
                if (~alu_borrow)
                begin
                    start_next = end_reg;
                    idx_next   = idx_reg + CNT_W'(1);
                end
            end
            S_FIND_WITHIN:
            begin
                within_next = alu_res[LEN_W-1:0];
            end
            S_EMIT_AVAIL:
            begin
                avail_next = alu_res[LEN_W-1:0];
            end
            S_EMIT_TAKE:
            begin
                take_next = alu_borrow ? remaining_reg[LEN_W-1:0] : avail_reg;
            end
            S_EMIT_ADDR:
            begin
                addr_next = alu_res[ADDR_BITS-1:0];
            end
            S_EMIT_REM:
            begin
                remaining_next = alu_res[OFS_W-1:0];
            end
            S_EMIT_COV:
            begin
                covered_next = alu_res[OFS_W-1:0];
            end
            // A new segment pushes the held one out as a non-final result
            S_EMIT_PUSH:
            begin
                if (~pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_addr_next   = FIELD_AW'(pend_addr_reg);
                        out_len_next    = pend_len_reg;
                        out_cov_next    = pend_cov_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_addr_next  = addr_reg;
                    pend_len_next   = take_reg;
                    pend_cov_next   = covered_reg;
                end
            end
            S_EMIT_NEXT:
            begin
                idx_next    = idx_reg + CNT_W'(1);
                within_next = '0;
            end
            // Final result of the transaction
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_addr_next = FIELD_AW'(pend_addr_reg);
                        out_len_next  = pend_len_reg;
                        out_cov_next  = pend_cov_reg;
                    end
                    else
                    begin
                        out_addr_next = '0;
                        out_len_next  = '0;
                        out_cov_next  = '0;
                    end
                    case (cmd_reg)
                        CMD_WALK_IN:
                        begin
                            out_status_next = (remaining_reg != '0) ? ST_MORE : ST_OK;
                        end
                        CMD_WALK_OUT:
                        begin
                            out_status_next = ST_OK;
                        end
                        default:
                        begin
                            out_status_next = resp_status_reg;
                        end
                    endcase
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                out_last_next = out_last_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        len_reg         <= len_next;
        offset_reg      <= offset_next;
        buflen_reg      <= buflen_next;
        resp_status_reg <= resp_status_next;
        idx_reg         <= idx_next;
        remaining_reg   <= remaining_next;
        start_reg       <= start_next;
        end_reg         <= end_next;
        within_reg      <= within_next;
        avail_reg       <= avail_next;
        take_reg        <= take_next;
        addr_reg        <= addr_next;
        covered_reg     <= covered_next;
        pend_addr_reg   <= pend_addr_next;
        pend_len_reg    <= pend_len_next;
        pend_cov_reg    <= pend_cov_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
        out_len_reg     <= out_len_next;
        out_cov_reg     <= out_cov_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign seg_addr      = out_addr_reg;
    assign seg_length    = out_len_reg;
    assign covered_total = out_cov_reg;
    assign last          = out_last_reg;

endmodule
